FILE: hw/rtl/osbb_pkg.sv
`timescale 1ns / 1ps

package osbb_pkg;

    localparam int COORD_FRAC_BITS = 16;

    localparam int POS_W  = 32;
    localparam int QUAT_W = 16;
    localparam int SIZE_W = 31;
    localparam int PROD_W = 2 * QUAT_W;
    localparam int ENT_W  = PROD_W + 2;
    localparam int RND_SH = 14;
    localparam int MAG_W  = ENT_W - RND_SH - 1;
    localparam int TERM_W = MAG_W + SIZE_W;
    localparam int SUM_W  = TERM_W + 2;
    localparam int EXT_W  = SUM_W - RND_SH;
    localparam int RES_W  = EXT_W + 2;

    localparam logic [ENT_W-1:0] ENT_ROUND = ENT_W'(1) << (RND_SH - 1);
    localparam logic [SUM_W-1:0] SUM_ROUND = SUM_W'(1) << (RND_SH - 1);

    localparam logic [EXT_W-1:0] PLANE_EXT_XZ = EXT_W'(500) << COORD_FRAC_BITS;
    localparam logic [EXT_W-1:0] PLANE_EXT_Y  = EXT_W'(1) << COORD_FRAC_BITS;

    typedef enum logic [1:0] {
        KIND_SPHERE = 2'd0,
        KIND_BOX    = 2'd1,
        KIND_PLANE  = 2'd2,
        KIND_OTHER  = 2'd3
    } kind_t;

endpackage

FILE: hw/rtl/oriented_shape_bounding_box.sv
// Throughput: one beat per cycle; six register stages, each holding one beat,
// with per-stage ready so bubbles collapse and a stall holds every stage.
// The 19x31 magnitude-by-size multiplies in stage 4 set the stage depth.
// Reset (rst_n low, asynchronous) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps

module oriented_shape_bounding_box (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [osbb_pkg::POS_W-1:0]   pos_x,
    input  logic signed [osbb_pkg::POS_W-1:0]   pos_y,
    input  logic signed [osbb_pkg::POS_W-1:0]   pos_z,
    input  logic signed [osbb_pkg::QUAT_W-1:0]  quat_x,
    input  logic signed [osbb_pkg::QUAT_W-1:0]  quat_y,
    input  logic signed [osbb_pkg::QUAT_W-1:0]  quat_z,
    input  logic signed [osbb_pkg::QUAT_W-1:0]  quat_w,
    input  logic [1:0]                          shape_kind,
    input  logic [osbb_pkg::SIZE_W-1:0]         size_x,
    input  logic [osbb_pkg::SIZE_W-1:0]         size_y,
    input  logic [osbb_pkg::SIZE_W-1:0]         size_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [osbb_pkg::POS_W-1:0]   min_x,
    output logic signed [osbb_pkg::POS_W-1:0]   min_y,
    output logic signed [osbb_pkg::POS_W-1:0]   min_z,
    output logic signed [osbb_pkg::POS_W-1:0]   max_x,
    output logic signed [osbb_pkg::POS_W-1:0]   max_y,
    output logic signed [osbb_pkg::POS_W-1:0]   max_z
);

    localparam int PW = osbb_pkg::POS_W;
    localparam int SW = osbb_pkg::SIZE_W;
    localparam int QP = osbb_pkg::PROD_W;
    localparam int EW = osbb_pkg::ENT_W;
    localparam int MW = osbb_pkg::MAG_W;
    localparam int TW = osbb_pkg::TERM_W;
    localparam int UW = osbb_pkg::SUM_W;
    localparam int XW = osbb_pkg::EXT_W;
    localparam int RW = osbb_pkg::RES_W;
    localparam int RS = osbb_pkg::RND_SH;

    function automatic logic [PW-1:0] sat_pos(input logic signed [RW-1:0] v);
        logic hi_same;
        begin
            hi_same = (v[RW-1:PW-1] == {(RW-PW+1){v[PW-1]}});
            if (hi_same)
            begin
                sat_pos = v[PW-1:0];
            end
            else if (v[RW-1])
            begin
                sat_pos = {1'b1, {(PW-1){1'b0}}};
            end
            else
            begin
                sat_pos = {1'b0, {(PW-1){1'b1}}};
            end
        end
    endfunction

    // stage valids and per-stage enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !v6_reg || out_ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign in_ready  = en1;
    assign out_valid = v6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // stage 1: quaternion products
    // order: xx yy zz ww xy xz yz wx wy wz
    logic signed [QP-1:0]  prod_next [10];
    logic signed [QP-1:0]  prod_reg  [10];
    logic [2:0][PW-1:0]    pos1_reg;
    logic [2:0][SW-1:0]    size1_reg;
    osbb_pkg::kind_t       kind1_reg;

    always_comb
    begin
        prod_next[0] = quat_x * quat_x;
        prod_next[1] = quat_y * quat_y;
        prod_next[2] = quat_z * quat_z;
        prod_next[3] = quat_w * quat_w;
        prod_next[4] = quat_x * quat_y;
        prod_next[5] = quat_x * quat_z;
        prod_next[6] = quat_y * quat_z;
        prod_next[7] = quat_w * quat_x;
        prod_next[8] = quat_w * quat_y;
        prod_next[9] = quat_w * quat_z;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int i = 0; i < 10; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            pos1_reg  <= {pos_z, pos_y, pos_x};
            size1_reg <= {size_z, size_y, size_x};
            kind1_reg <= osbb_pkg::kind_t'(shape_kind);
        end
    end

    // stage 2: rotation matrix entries, row-major
    logic signed [EW-1:0]  ent_next [9];
    logic signed [EW-1:0]  ent_reg  [9];
    logic [2:0][PW-1:0]    pos2_reg;
    logic [2:0][SW-1:0]    size2_reg;
    osbb_pkg::kind_t       kind2_reg;

    always_comb
    begin
        logic signed [EW-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
        xx = EW'(prod_reg[0]);
        yy = EW'(prod_reg[1]);
        zz = EW'(prod_reg[2]);
        ww = EW'(prod_reg[3]);
        xy = EW'(prod_reg[4]);
        xz = EW'(prod_reg[5]);
        yz = EW'(prod_reg[6]);
        wx = EW'(prod_reg[7]);
        wy = EW'(prod_reg[8]);
        wz = EW'(prod_reg[9]);
        ent_next[0] = ww + xx - yy - zz;
        ent_next[1] = (xy - wz) <<< 1;
        ent_next[2] = (xz + wy) <<< 1;
        ent_next[3] = (xy + wz) <<< 1;
        ent_next[4] = ww - xx + yy - zz;
        ent_next[5] = (yz - wx) <<< 1;
        ent_next[6] = (xz - wy) <<< 1;
        ent_next[7] = (yz + wx) <<< 1;
        ent_next[8] = ww - xx - yy + zz;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int i = 0; i < 9; i++)
            begin
                ent_reg[i] <= ent_next[i];
            end
            pos2_reg  <= pos1_reg;
            size2_reg <= size1_reg;
            kind2_reg <= kind1_reg;
        end
    end

    // stage 3: rounded magnitudes
    logic [MW-1:0]         mag_next [9];
    logic [MW-1:0]         mag_reg  [9];
    logic [2:0][PW-1:0]    pos3_reg;
    logic [2:0][SW-1:0]    size3_reg;
    osbb_pkg::kind_t       kind3_reg;

    always_comb
    begin
        logic [EW-1:0] a;
        logic [EW-1:0] r;
        for (int i = 0; i < 9; i++)
        begin
            a = ent_reg[i][EW-1] ? EW'(-ent_reg[i]) : EW'(ent_reg[i]);
            r = a + osbb_pkg::ENT_ROUND;
            mag_next[i] = r[MW+RS-1:RS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            for (int i = 0; i < 9; i++)
            begin
                mag_reg[i] <= mag_next[i];
            end
            pos3_reg  <= pos2_reg;
            size3_reg <= size2_reg;
            kind3_reg <= kind2_reg;
        end
    end

    // stage 4: magnitude times local half-extent
    logic [TW-1:0]         term_next [9];
    logic [TW-1:0]         term_reg  [9];
    logic [2:0][PW-1:0]    pos4_reg;
    logic [SW-1:0]         radius4_reg;
    osbb_pkg::kind_t       kind4_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                term_next[r*3+c] = TW'(mag_reg[r*3+c]) * TW'(size3_reg[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            for (int i = 0; i < 9; i++)
            begin
                term_reg[i] <= term_next[i];
            end
            pos4_reg    <= pos3_reg;
            radius4_reg <= size3_reg[0];
            kind4_reg   <= kind3_reg;
        end
    end

    // stage 5: row sums and extent select by kind
    logic [2:0][XW-1:0]    ext_next;
    logic [2:0][XW-1:0]    ext5_reg;
    logic [2:0][PW-1:0]    pos5_reg;

    always_comb
    begin
        logic [UW-1:0] acc;
        for (int r = 0; r < 3; r++)
        begin
            acc = UW'(term_reg[r*3]) + UW'(term_reg[r*3+1]) + UW'(term_reg[r*3+2])
                + osbb_pkg::SUM_ROUND;
            case (kind4_reg)
                osbb_pkg::KIND_SPHERE: ext_next[r] = XW'(radius4_reg);
                osbb_pkg::KIND_BOX:    ext_next[r] = acc[UW-1:RS];
                osbb_pkg::KIND_PLANE:  ext_next[r] = (r == 1) ? osbb_pkg::PLANE_EXT_Y
                                                              : osbb_pkg::PLANE_EXT_XZ;
                default:               ext_next[r] = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            ext5_reg <= ext_next;
            pos5_reg <= pos4_reg;
        end
    end

    // stage 6: min/max with saturation, output register
    logic [2:0][PW-1:0] min_next, max_next;
    logic [2:0][PW-1:0] min_reg, max_reg;

    always_comb
    begin
        logic signed [RW-1:0] p, e;
        for (int i = 0; i < 3; i++)
        begin
            p = RW'($signed(pos5_reg[i]));
            e = $signed({2'b00, ext5_reg[i]});
            min_next[i] = sat_pos(p - e);
            max_next[i] = sat_pos(p + e);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign min_x = min_reg[0];
    assign min_y = min_reg[1];
    assign min_z = min_reg[2];
    assign max_x = max_reg[0];
    assign max_y = max_reg[1];
    assign max_z = max_reg[2];

    // extents are never negative
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (min_x <= max_x) && (min_y <= max_y) && (min_z <= max_z))
        else $error("min above max");

    // unknown kind collapses the box to the centre
    a_other_point: assert property (@(posedge clk) disable iff (!rst_n)
        (en5 && v4_reg && kind4_reg == osbb_pkg::KIND_OTHER)
            |=> (ext5_reg == '0))
        else $error("unknown kind gave nonzero extent");

    // input is refused only with every stage full
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && v6_reg)
        else $error("input refused with a free stage");

    // a stalled middle stage keeps its beat
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !en4) |=> v3_reg && v4_reg)
        else $error("beat lost in stall");

endmodule
